### rtl/itrt_pkg.sv
// Package: shared constants, controller state, command/status structs and digit lookup.
package itrt_pkg;

   localparam int DEF_VALUE_WIDTH = 32;
   localparam int DEF_MAX_DIGITS  = 32;

   localparam int RADIX_W = 6;
   localparam int DIGIT_W = 6;
   localparam int CHAR_W  = 8;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
   localparam logic [DIGIT_W-1:0] DIGIT_TEN = 6'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_STORE,
      ST_SIGN,
      ST_READ,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;        // take a new item
      logic div_step;    // one restoring divide step
      logic digit_write; // store remainder, advance digit count
      logic rd_issue;    // read next digit, most significant first
      logic out_sign;    // load '-' into output register
      logic out_digit;   // load digit character into output register
   } dp_cmd_type;

   typedef struct packed {
      logic step_last;   // divide finishes this cycle
      logic quot_zero;   // quotient is zero
      logic digits_full; // no room for another digit
      logic count_zero;  // all digits read out
      logic negative;    // text starts with '-'
      logic out_free;    // output register can take a character
   } dp_stat_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < DIGIT_TEN) begin
         c = CHAR_ZERO + CHAR_W'(d);
      end else begin
         c = CHAR_LOW_A + CHAR_W'(d - DIGIT_TEN);
      end
      return c;
   endfunction

endpackage

### rtl/itrt_ram.sv
// Generic single-port-write, registered-read RAM.
module itrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/itrt_datapath.sv
// Datapath: input capture, bit-serial radix divider, digit store and output register.
module itrt_datapath import itrt_pkg::*; #(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
   parameter int MAX_DIGITS  = DEF_MAX_DIGITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [VALUE_WIDTH-1:0] req_number,
   input  logic [RADIX_W-1:0]            req_base,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [CHAR_W-1:0]             rsp_text_char,
   output logic                          rsp_last_char,
   input  dp_cmd_type                    cmd,
   output dp_stat_type                   stat
);

   localparam int STEP_W = $clog2(VALUE_WIDTH);
   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W  = $clog2(MAX_DIGITS);

   logic [VALUE_WIDTH-1:0] work_ff, work_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [RADIX_W-1:0]     radix_ff, radix_in;
   logic                   neg_ff, neg_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]      char_ff, char_in;
   logic                   last_ff, last_in;

   logic [VALUE_WIDTH-1:0] num_u;
   logic [RADIX_W-1:0]     radix_sat;
   logic                   neg_new;
   logic [DIGIT_W:0]       trial;
   logic                   ge;
   logic [CNT_W:0]         slots;
   logic [CNT_W:0]         count_next;
   logic [CNT_W-1:0]       count_dec;
   logic [DIGIT_W-1:0]     rd_digit;
   logic                   out_free;

   assign num_u = req_number;

   always_comb begin
      priority if (req_base < RADIX_MIN) begin
         radix_sat = RADIX_MIN;
      end else if (req_base > RADIX_MAX) begin
         radix_sat = RADIX_MAX;
      end else begin
         radix_sat = req_base;
      end
   end

   assign neg_new = (radix_sat == RADIX_DEC) && num_u[VALUE_WIDTH-1];

   // restoring step: bring in the next dividend bit, subtract when it fits
   assign trial = {rem_ff, work_ff[VALUE_WIDTH-1]};
   assign ge    = trial >= {1'b0, radix_ff};

   assign slots      = neg_ff ? (CNT_W+1)'(MAX_DIGITS - 1) : (CNT_W+1)'(MAX_DIGITS);
   assign count_next = {1'b0, count_ff} + 1'b1;
   assign count_dec  = count_ff - 1'b1;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      work_in      = work_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      radix_in     = radix_ff;
      neg_in       = neg_ff;
      count_in     = count_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         work_in  = neg_new ? (~num_u + 1'b1) : num_u;
         rem_in   = '0;
         step_in  = '0;
         radix_in = radix_sat;
         neg_in   = neg_new;
         count_in = '0;
      end
      if (cmd.div_step) begin
         work_in = {work_ff[VALUE_WIDTH-2:0], ge};
         rem_in  = ge ? DIGIT_W'(trial - {1'b0, radix_ff}) : DIGIT_W'(trial);
         step_in = step_ff + 1'b1;
      end
      if (cmd.digit_write) begin
         count_in = count_next[CNT_W-1:0];
         rem_in   = '0;
         step_in  = '0;
      end
      if (cmd.rd_issue) begin
         count_in = count_dec;
      end
      if (cmd.out_sign) begin
         char_in      = CHAR_MINUS;
         last_in      = 1'b0;
         rsp_valid_in = 1'b1;
      end
      if (cmd.out_digit) begin
         char_in      = digit_char(rd_digit);
         last_in      = (count_ff == '0);
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         neg_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         neg_ff       <= neg_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      radix_ff <= radix_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   itrt_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (MAX_DIGITS)
   ) u_digit_store (
      .clock   (clock),
      .wr_en   (cmd.digit_write),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (rem_ff),
      .rd_en   (cmd.rd_issue),
      .rd_addr (count_dec[IDX_W-1:0]),
      .rd_data (rd_digit)
   );

   assign stat.step_last   = (step_ff == STEP_W'(VALUE_WIDTH - 1));
   assign stat.quot_zero   = (work_ff == '0);
   assign stat.digits_full = (count_next >= slots);
   assign stat.count_zero  = (count_ff == '0);
   assign stat.negative    = neg_ff;
   assign stat.out_free    = out_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = char_ff;
   assign rsp_last_char = last_ff;

endmodule

### rtl/itrt_ctrl.sv
// Controller: sequences divide, digit store, sign and character read-out.
module itrt_ctrl import itrt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.step_last) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            // work register already holds the quotient here
            cmd.digit_write = 1'b1;
            if (stat.quot_zero || stat.digits_full) begin
               state_in = stat.negative ? ST_SIGN : ST_READ;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_SIGN: begin
            if (stat.out_free) begin
               cmd.out_sign = 1'b1;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.out_digit = 1'b1;
               state_in      = stat.count_zero ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/integer_to_radix_text_unit.sv
// Top level: integer to radix text conversion, one character per result item.
// Each digit comes from the one-bit-per-cycle radix divider and is then stored; each
//   character is then a store read and an output load, a leading '-' an output load alone;
// rsp stalls can hold any of these output loads.
// One item at a time: a new item is taken only after the last character of the previous one.
// Reset clears the controller, count, sign and output valid; the digit store is not cleared.
module integer_to_radix_text_unit import itrt_pkg::*; #(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
   parameter int MAX_DIGITS  = DEF_MAX_DIGITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_number,
   input  logic [RADIX_W-1:0]            req_base,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [CHAR_W-1:0]             rsp_text_char,
   output logic                          rsp_last_char
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   itrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   itrt_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_DIGITS  (MAX_DIGITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_number    (req_number),
      .req_base      (req_base),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char),
      .cmd           (cmd),
      .stat          (stat)
   );

endmodule

### test/integer_to_radix_text_checker.sv
// Checker: watches both channels, predicts the radix text of every item and compares results.
module integer_to_radix_text_checker import itrt_pkg::*; (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic signed [DEF_VALUE_WIDTH-1:0] req_number,
   input  logic [RADIX_W-1:0]                req_base,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [CHAR_W-1:0]                 rsp_text_char,
   input  logic                              rsp_last_char,
   output int                                mismatch_count,
   output int                                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_W    = DEF_VALUE_WIDTH;
   localparam int MAX_TEXT = DEF_MAX_DIGITS;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [CHAR_W-1:0] text_char;
      logic              last_char;
   } text_char_type;

   text_char_type text_queue[$];
   int            errors;

   // radix text of one item, most significant character first
   task automatic predict_text(input logic [NUM_W-1:0] number, input logic [RADIX_W-1:0] base);
      string            digit_set;
      logic [RADIX_W-1:0] radix;
      logic [NUM_W-1:0] rest;
      logic [DIGIT_W-1:0] digits[MAX_TEXT];
      int               n;
      int               slots;
      bit               minus;
      text_char_type    t;
      digit_set = "0123456789abcdefghijklmnopqrstuvwxyz";
      radix = (base < RADIX_MIN) ? RADIX_MIN : (base > RADIX_MAX) ? RADIX_MAX : base;
      // only decimal shows a sign; other radices read the bits as unsigned
      minus = (radix == RADIX_DEC) && number[NUM_W-1];
      rest  = minus ? (NUM_W'(0) - number) : number;
      slots = minus ? MAX_TEXT - 1 : MAX_TEXT;
      n = 0;
      do begin
         digits[n] = DIGIT_W'(rest % NUM_W'(radix));
         n++;
         rest = rest / NUM_W'(radix);
      end while (rest != 0 && n < slots);
      if (minus) begin
         t.text_char = CHAR_MINUS;
         t.last_char = 1'b0;
         text_queue.push_back(t);
      end
      for (int k = n - 1; k >= 0; k--) begin
         t.text_char = CHAR_W'(digit_set[digits[k]]);
         t.last_char = (k == 0);
         text_queue.push_back(t);
      end
   endtask

   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         text_queue.delete();
         errors = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (text_queue.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("unexpected item: char %h last %b", rsp_text_char, rsp_last_char);
            end else begin
               want = text_queue.pop_front();
               if (rsp_text_char !== want.text_char || rsp_last_char !== want.last_char) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display("mismatch: char exp %h got %h, last exp %b got %b",
                              want.text_char, rsp_text_char, want.last_char, rsp_last_char);
               end
            end
         end
         if (req_valid && !req_stall)
            predict_text(req_number, req_base);
      end
      mismatch_count <= errors;
      pending_count  <= text_queue.size();
   end

endmodule

### test/integer_to_radix_text_unit_tb.sv
// Testbench top: drives integer items into the radix text unit and gives the verdict.
module integer_to_radix_text_unit_tb import itrt_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_W        = DEF_VALUE_WIDTH;
   localparam int RANDOM_ITEMS = 190;
   localparam int HOLD_CYCLES  = 3000;
   localparam int HOLD_AT_ITEM = 100;
   localparam int IDLE_LIMIT   = 20000;
   localparam int TAIL_CYCLES  = 64;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic signed [NUM_W-1:0] req_number;
   logic [RADIX_W-1:0]      req_base;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [CHAR_W-1:0]       rsp_text_char;
   logic                    rsp_last_char;

   int mismatch_count;
   int pending_count;
   int items_sent;
   int burst_left;
   int idle_cycles;

   integer_to_radix_text_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_number    (req_number),
      .req_base      (req_base),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char)
   );

   integer_to_radix_text_checker text_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_number     (req_number),
      .req_base       (req_base),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_text_char  (rsp_text_char),
      .rsp_last_char  (rsp_last_char),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic offer_item(input logic [NUM_W-1:0] number, input logic [RADIX_W-1:0] base);
      @(negedge clock);
      req_valid  <= 1'b1;
      req_number <= number;
      req_base   <= base;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      items_sent++;
   endtask

   // bursts of items, then mostly a gap with valid low
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 25);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic send_one(input logic [NUM_W-1:0] number, input logic [RADIX_W-1:0] base);
      offer_item(number, base);
      pace_sender();
   endtask

   // receiver stall pattern, with one long hold-off to back the block up
   initial begin
      int  mode;
      int  run;
      int  hold_left;
      int  phase;
      bit  held;
      rsp_stall = 1'b0;
      hold_left = 0;
      held = 1'b0;
      phase = 0;
      forever begin
         mode = $urandom_range(0, 3);
         run  = $urandom_range(5, 80);
         repeat (run) begin
            @(negedge clock);
            phase++;
            if (!held && items_sent >= HOLD_AT_ITEM) begin
               held = 1'b1;
               hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_stall <= 1'b1;
            end else begin
               case (mode)
                  0:       rsp_stall <= 1'b0;
                  1:       rsp_stall <= 1'($urandom_range(0, 1));
                  2:       rsp_stall <= ($urandom_range(0, 3) != 0);
                  default: rsp_stall <= (phase % 3 == 0);
               endcase
            end
         end
      end
   end

   // watchdog: cycles with no item moving on either channel
   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("integer_to_radix_text_unit_tb NOT OK");
      $finish;
   end

   initial begin
      logic [NUM_W-1:0]   num;
      logic [RADIX_W-1:0] base;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_number = '0;
      req_base   = '0;
      items_sent = 0;
      burst_left = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero, sign handling, widest texts, radix saturation, letter digits
      send_one(32'd0, 6'd10);
      send_one(32'd0, 6'd2);
      send_one(32'd0, 6'd36);
      send_one(32'h7fffffff, 6'd10);
      send_one(32'h80000000, 6'd10);
      send_one(32'hffffffff, 6'd10);
      send_one(32'hffffffff, 6'd16);
      send_one(32'h80000000, 6'd2);
      send_one(32'hffffffff, 6'd2);
      send_one(32'haaaaaaaa, 6'd2);
      send_one(32'h55555555, 6'd8);
      send_one(32'd1537019, 6'd36);
      send_one(32'hffffffff, 6'd36);
      send_one(32'd1234, 6'd0);
      send_one(32'd1234, 6'd1);
      send_one(32'd1234, 6'd37);
      send_one(32'd1234, 6'd63);
      send_one(-32'sd1234, 6'd63);
      send_one(-32'sd5, 6'd0);
      send_one(-32'sd42, 6'd10);
      send_one(32'd255, 6'd16);
      send_one(32'd9, 6'd10);
      send_one(32'd10, 6'd36);
      send_one(32'd35, 6'd35);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         case ($urandom_range(0, 5))
            0: num = $urandom;
            1: num = NUM_W'($urandom_range(0, 99));
            2: num = NUM_W'(0) - NUM_W'($urandom_range(1, 999));
            3: begin
               case ($urandom_range(0, 3))
                  0:       num = 32'h80000000;
                  1:       num = 32'h7fffffff;
                  2:       num = 32'hffffffff;
                  default: num = 32'h00000001;
               endcase
            end
            default: begin
               num = $urandom >> $urandom_range(0, 31);
               if ($urandom_range(0, 1) == 1) num = NUM_W'(0) - num;
            end
         endcase
         case ($urandom_range(0, 7))
            0, 1:    base = RADIX_DEC;
            2:       base = RADIX_W'($urandom_range(0, 63));
            3:       base = RADIX_W'($urandom_range(2, 4));
            default: base = RADIX_W'($urandom_range(2, 36));
         endcase
         send_one(num, base);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("integer_to_radix_text_unit_tb OK");
      else
         $display("integer_to_radix_text_unit_tb NOT OK");
      $finish;
   end

endmodule
